>>> src/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared definitions for the shell contact density block
// Operation codes, status codes, register indexes, sequencer states and the
// fixed-point volume constant.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam logic [1:0] OP_LOAD_PROBE  = 2'd0;
   localparam logic [1:0] OP_LOAD_TARGET = 2'd1;
   localparam logic [1:0] OP_COMPUTE     = 2'd2;
   localparam logic [1:0] OP_CLEAR_PROBE = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   localparam logic [2:0] REG_INNER     = 3'd0;
   localparam logic [2:0] REG_OUTER     = 3'd1;
   localparam logic [2:0] REG_BOX_X     = 3'd2;
   localparam logic [2:0] REG_BOX_Y     = 3'd3;
   localparam logic [2:0] REG_BOX_Z     = 3'd4;
   localparam logic [2:0] REG_REIMAGE   = 3'd5;
   localparam logic [2:0] REG_AVERAGE   = 3'd6;
   localparam logic [2:0] REG_NORMALIZE = 3'd7;

   // 4*pi/3 in unsigned Q.32.
   localparam logic [47:0] VOL_K = 48'd17990716939;

   localparam int NUM_W = 104;
   localparam int DEN_W = 48;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RSQ,
      ST_OSQ,
      ST_RCU,
      ST_OCU,
      ST_DIF,
      ST_RD,
      ST_AX,
      ST_AY,
      ST_AZ,
      ST_CMP,
      ST_POST,
      ST_LAUNCH,
      ST_WAIT,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      DIV_T,
      DIV_K,
      DIV_D
   } div_stage_type;

endpackage

>>> src/ssc_axis_gap.sv
// ----------------------------------------------------------------------------
// ssc_axis_gap: per-axis separation with optional minimum image
// Gives |p - t|, folded once by the box length when it exceeds half a box.
// ----------------------------------------------------------------------------
module ssc_axis_gap
   import ssc_pkg::*;
(
   input  logic signed [23:0] probe_pos,
   input  logic signed [23:0] target_pos,
   input  logic        [23:0] box_len,
   input  logic               reimage_on,
   output logic        [24:0] gap
);

   logic signed [24:0] diff;
   logic        [24:0] mag;
   logic        [25:0] twice;

   always_comb begin
      diff  = 25'(probe_pos) - 25'(target_pos);
      mag   = diff[24] ? 25'(-diff) : 25'(diff);
      twice = {mag, 1'b0};
      gap   = mag;
      if (reimage_on && (twice > {2'b00, box_len})) begin
         if (mag > {1'b0, box_len}) begin
            gap = mag - {1'b0, box_len};
         end else begin
            gap = {1'b0, box_len} - mag;
         end
      end
   end

endmodule

>>> src/ssc_divider.sv
// ----------------------------------------------------------------------------
// ssc_divider: restoring divider, one quotient bit per cycle
// Divides a 104-bit numerator by a non-zero 48-bit divisor.
// ----------------------------------------------------------------------------
module ssc_divider
   import ssc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             div_start,
   input  logic [NUM_W-1:0] div_num,
   input  logic [DEN_W-1:0] div_den,
   output logic             div_busy,
   output logic             div_done,
   output logic [NUM_W-1:0] div_quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] nq_ff, nq_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, nq_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      nq_in   = nq_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_start) begin
         rem_in  = '0;
         nq_in   = div_num;
         den_in  = div_den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         nq_in  = {nq_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      den_ff <= den_in;
   end

   assign div_busy = busy_ff;
   assign div_done = done_ff;
   assign div_quo  = nq_ff;

`ifndef NO_ASSERTIONS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      div_done |-> $past(busy_ff))
      else $error("divider finished without running");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !busy_ff)
      else $error("divider restarted while running");
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(div_start) |-> rem_ff < den_ff)
      else $error("divider remainder out of range");
`endif

endmodule

>>> src/spherical_shell_contact_density.sv
// ----------------------------------------------------------------------------
// spherical_shell_contact_density: shell neighbour count and density
// Loads target and probe atoms, then counts pairs inside a spherical shell.
// ----------------------------------------------------------------------------
// Usage. A request is taken when start is high and busy is low. Operation
// load probe or load target stores one atom (a load into a full list is
// dropped); clear probes empties the probe list. None of these gives a
// result. Compute walks every target-probe pair through the three gap units
// and one shared multiplier, then runs up to three divisions on a shared
// restoring divider (by the target count, the volume constant and the
// shell cube difference). Busy stays high until the cycle before the
// result appears. It is on the rsp_ ports for one cycle with rsp_valid,
// and compute empties the target list. A compute with no targets answers
// on the next cycle without going busy. The receiver cannot stall the block.
// Registers are written through the csr_ channel, which is always ready.
// Reset clears both atom counts and loads register defaults; atom stores need
// no clearing.
// ----------------------------------------------------------------------------
module spherical_shell_contact_density
   import ssc_pkg::*;
#(
   parameter int MAX_TARGETS = 1024,
   parameter int MAX_PROBES  = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [23:0] req_pos_x,
   input  logic [23:0] req_pos_y,
   input  logic [23:0] req_pos_z,
   output logic        rsp_valid,
   output logic [47:0] rsp_density_value,
   output logic [23:0] rsp_contact_total,
   output logic [10:0] rsp_targets_used,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int TA_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int PA_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
   localparam int TC_W = $clog2(MAX_TARGETS + 1);
   localparam int PC_W = $clog2(MAX_PROBES + 1);

   // Configuration registers.
   logic [15:0] inner_ff, outer_ff;
   logic [23:0] box_x_ff, box_y_ff, box_z_ff;
   logic        reimage_ff, average_ff, normalize_ff;

   // Atom stores.
   logic [71:0] tgt_mem [MAX_TARGETS];
   logic [71:0] prb_mem [MAX_PROBES];
   logic [71:0] tgt_rd_ff, prb_rd_ff;

   logic [TC_W-1:0] tcount_ff, tcount_in;
   logic [PC_W-1:0] pcount_ff, pcount_in;
   logic [TA_W-1:0] tidx_ff, tidx_in;
   logic [PA_W-1:0] pidx_ff, pidx_in;

   state_type     state_ff, state_in;
   div_stage_type stage_ff, stage_in;

   logic [31:0]    ir2_ff, ir2_in, or2_ff, or2_in;
   logic [47:0]    ri3_ff, ri3_in, dvol_ff, dvol_in;
   logic           dzero_ff, dzero_in;
   logic [49:0]    sq_ff, sq_in;
   logic [50:0]    acc_ff, acc_in;
   logic [23:0]    count_ff, count_in;
   logic           sat_ff, sat_in;
   logic [NUM_W-1:0] quo_ff, quo_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [47:0]    rsp_dens_ff, rsp_dens_in;
   logic [23:0]    rsp_count_ff, rsp_count_in;
   logic [10:0]    rsp_tused_ff, rsp_tused_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;

   logic [31:0]    mul_a;
   logic [24:0]    mul_b;
   logic [56:0]    mul_p;
   logic [24:0]    gap_x, gap_y, gap_z;
   logic [51:0]    d2;
   logic           accept, tgt_wr, prb_wr;
   logic           last_p, last_t;
   logic [TC_W+47:0] tc_wide;

   logic             div_start, div_busy, div_done;
   logic [DEN_W-1:0] div_den;
   logic [NUM_W-1:0] div_quo;

   assign accept    = start && (state_ff == ST_IDLE);
   assign tgt_wr    = accept && (req_operation == OP_LOAD_TARGET)
                      && (tcount_ff < TC_W'(MAX_TARGETS));
   assign prb_wr    = accept && (req_operation == OP_LOAD_PROBE)
                      && (pcount_ff < PC_W'(MAX_PROBES));
   assign csr_ready = 1'b1;
   assign tc_wide   = {48'd0, tcount_ff};

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff     <= 16'd0;
         outer_ff     <= 16'd1280;
         box_x_ff     <= 24'd0;
         box_y_ff     <= 24'd0;
         box_z_ff     <= 24'd0;
         reimage_ff   <= 1'b1;
         average_ff   <= 1'b1;
         normalize_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_INNER:     inner_ff     <= csr_data[15:0];
            REG_OUTER:     outer_ff     <= csr_data[15:0];
            REG_BOX_X:     box_x_ff     <= csr_data;
            REG_BOX_Y:     box_y_ff     <= csr_data;
            REG_BOX_Z:     box_z_ff     <= csr_data;
            REG_REIMAGE:   reimage_ff   <= csr_data[0];
            REG_AVERAGE:   average_ff   <= csr_data[0];
            REG_NORMALIZE: normalize_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Stores: one write port, one registered read port each.
   always_ff @(posedge clock) begin
      if (tgt_wr) begin
         tgt_mem[tcount_ff[TA_W-1:0]] <= {req_pos_x, req_pos_y, req_pos_z};
      end
      tgt_rd_ff <= tgt_mem[tidx_ff];
   end

   always_ff @(posedge clock) begin
      if (prb_wr) begin
         prb_mem[pcount_ff[PA_W-1:0]] <= {req_pos_x, req_pos_y, req_pos_z};
      end
      prb_rd_ff <= prb_mem[pidx_ff];
   end

   ssc_axis_gap u_gap_x (
      .probe_pos  (prb_rd_ff[71:48]),
      .target_pos (tgt_rd_ff[71:48]),
      .box_len    (box_x_ff),
      .reimage_on (reimage_ff),
      .gap        (gap_x)
   );

   ssc_axis_gap u_gap_y (
      .probe_pos  (prb_rd_ff[47:24]),
      .target_pos (tgt_rd_ff[47:24]),
      .box_len    (box_y_ff),
      .reimage_on (reimage_ff),
      .gap        (gap_y)
   );

   ssc_axis_gap u_gap_z (
      .probe_pos  (prb_rd_ff[23:0]),
      .target_pos (tgt_rd_ff[23:0]),
      .box_len    (box_z_ff),
      .reimage_on (reimage_ff),
      .gap        (gap_z)
   );

   // The single multiplier is shared by the radius powers and the axis squares.
   always_comb begin
      case (state_ff)
         ST_RSQ: begin
            mul_a = {16'd0, inner_ff};
            mul_b = {9'd0, inner_ff};
         end
         ST_OSQ: begin
            mul_a = {16'd0, outer_ff};
            mul_b = {9'd0, outer_ff};
         end
         ST_RCU: begin
            mul_a = ir2_ff;
            mul_b = {9'd0, inner_ff};
         end
         ST_OCU: begin
            mul_a = or2_ff;
            mul_b = {9'd0, outer_ff};
         end
         ST_AX: begin
            mul_a = {7'd0, gap_x};
            mul_b = gap_x;
         end
         ST_AY: begin
            mul_a = {7'd0, gap_y};
            mul_b = gap_y;
         end
         ST_AZ: begin
            mul_a = {7'd0, gap_z};
            mul_b = gap_z;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = {25'd0, mul_a} * {32'd0, mul_b};
   end

   ssc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (quo_ff),
      .div_den   (div_den),
      .div_busy  (div_busy),
      .div_done  (div_done),
      .div_quo   (div_quo)
   );

   always_comb begin
      case (stage_ff)
         DIV_T:   div_den = tc_wide[47:0];
         DIV_K:   div_den = VOL_K;
         DIV_D:   div_den = dvol_ff;
         default: div_den = VOL_K;
      endcase
   end

   assign d2     = 52'(acc_ff) + 52'(sq_ff);
   assign last_p = (PC_W + 1)'(pidx_ff) + 1'b1 == (PC_W + 1)'(pcount_ff);
   assign last_t = (TC_W + 1)'(tidx_ff) + 1'b1 == (TC_W + 1)'(tcount_ff);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      stage_in      = stage_ff;
      tcount_in     = tcount_ff;
      pcount_in     = pcount_ff;
      tidx_in       = tidx_ff;
      pidx_in       = pidx_ff;
      ir2_in        = ir2_ff;
      or2_in        = or2_ff;
      ri3_in        = ri3_ff;
      dvol_in       = dvol_ff;
      dzero_in      = dzero_ff;
      sq_in         = mul_p[49:0];
      acc_in        = acc_ff;
      count_in      = count_ff;
      sat_in        = sat_ff;
      quo_in        = quo_ff;
      div_start     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_dens_in   = rsp_dens_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_tused_in  = rsp_tused_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_LOAD_PROBE: begin
                     if (prb_wr) begin
                        pcount_in = pcount_ff + 1'b1;
                     end
                  end
                  OP_LOAD_TARGET: begin
                     if (tgt_wr) begin
                        tcount_in = tcount_ff + 1'b1;
                     end
                  end
                  OP_CLEAR_PROBE: pcount_in = '0;
                  OP_COMPUTE: begin
                     if (tcount_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_dens_in   = '0;
                        rsp_count_in  = '0;
                        rsp_tused_in  = '0;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_RSQ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RSQ: state_in = ST_OSQ;
         ST_OSQ: begin
            ir2_in   = sq_ff[31:0];
            state_in = ST_RCU;
         end
         ST_RCU: begin
            or2_in   = sq_ff[31:0];
            state_in = ST_OCU;
         end
         ST_OCU: begin
            ri3_in   = sq_ff[47:0];
            state_in = ST_DIF;
         end
         ST_DIF: begin
            dzero_in = sq_ff[47:0] <= ri3_ff;
            dvol_in  = sq_ff[47:0] - ri3_ff;
            count_in = '0;
            sat_in   = 1'b0;
            tidx_in  = '0;
            pidx_in  = '0;
            state_in = (pcount_ff == '0) ? ST_POST : ST_RD;
         end
         // Read data lands in the store output registers during this cycle.
         ST_RD: state_in = ST_AX;
         ST_AX: state_in = ST_AY;
         ST_AY: begin
            acc_in   = 51'(sq_ff);
            state_in = ST_AZ;
         end
         ST_AZ: begin
            acc_in   = acc_ff + 51'(sq_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((d2 >= 52'(ir2_ff)) && (d2 <= 52'(or2_ff))) begin
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  sat_in = 1'b1;
               end
            end
            state_in = ST_RD;
            if (last_p) begin
               pidx_in = '0;
               if (last_t) begin
                  state_in = ST_POST;
               end else begin
                  tidx_in = tidx_ff + 1'b1;
               end
            end else begin
               pidx_in = pidx_ff + 1'b1;
            end
         end
         ST_POST: begin
            quo_in = normalize_ff ? {count_ff, 80'd0} : {56'd0, count_ff, 24'd0};
            if (count_ff == '0) begin
               quo_in   = '0;
               state_in = ST_FIN;
            end else if (normalize_ff && dzero_ff) begin
               quo_in   = '1;
               state_in = ST_FIN;
            end else if (average_ff) begin
               stage_in = DIV_T;
               state_in = ST_LAUNCH;
            end else if (normalize_ff) begin
               stage_in = DIV_K;
               state_in = ST_LAUNCH;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               quo_in   = div_quo;
               state_in = ST_FIN;
               if (normalize_ff && (stage_ff == DIV_T)) begin
                  stage_in = DIV_K;
                  state_in = ST_LAUNCH;
               end else if (stage_ff == DIV_K) begin
                  stage_in = DIV_D;
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_count_in  = count_ff;
            rsp_tused_in  = tc_wide[10:0];
            rsp_dens_in   = quo_ff[47:0];
            rsp_status_in = sat_ff ? STATUS_SAT : STATUS_OK;
            if (quo_ff[NUM_W-1:48] != '0) begin
               rsp_dens_in   = '1;
               rsp_status_in = STATUS_SAT;
            end
            tcount_in = '0;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= DIV_T;
         tcount_ff    <= '0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         tcount_ff    <= tcount_in;
         pcount_ff    <= pcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tidx_ff       <= tidx_in;
      pidx_ff       <= pidx_in;
      ir2_ff        <= ir2_in;
      or2_ff        <= or2_in;
      ri3_ff        <= ri3_in;
      dvol_ff       <= dvol_in;
      dzero_ff      <= dzero_in;
      sq_ff         <= sq_in;
      acc_ff        <= acc_in;
      count_ff      <= count_in;
      sat_ff        <= sat_in;
      quo_ff        <= quo_in;
      rsp_dens_ff   <= rsp_dens_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_tused_ff  <= rsp_tused_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_density_value = rsp_dens_ff;
   assign rsp_contact_total = rsp_count_ff;
   assign rsp_targets_used  = rsp_tused_ff;
   assign rsp_status        = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_targets_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> tcount_ff == '0)
      else $error("target list not emptied after a result");
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |->
         (rsp_density_value == '0) && (rsp_contact_total == '0))
      else $error("empty target result carries data");
   a_wait_has_divider: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) && !div_done |-> div_busy)
      else $error("waiting on an idle divider");
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_EMPTY)
         || (rsp_status == STATUS_SAT))
      else $error("illegal status code");
`endif

endmodule

>>> dv/shell_density_checker.sv
// ----------------------------------------------------------------------------
// shell_density_checker: prediction and comparison for the shell density block
// Watches the request, register and result ports, keeps its own copy of the
// atom lists and registers, predicts each compute result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module shell_density_checker
   import ssc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [23:0] req_pos_x,
   input  logic [23:0] req_pos_y,
   input  logic [23:0] req_pos_z,
   input  logic        rsp_valid,
   input  logic [47:0] rsp_density_value,
   input  logic [23:0] rsp_contact_total,
   input  logic [10:0] rsp_targets_used,
   input  logic [1:0]  rsp_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          fail_count,
   output int          pending
);

   localparam int TARGET_CAP = 1024;
   localparam int PROBE_CAP  = 8192;
   localparam logic [47:0] DENSITY_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [23:0] CONTACT_MAX = 24'hFF_FFFF;

   typedef struct packed {
      logic [47:0] density;
      logic [23:0] contacts;
      logic [10:0] targets;
      logic [1:0]  status;
   } shell_result_type;

   logic [23:0] target_pos [TARGET_CAP][3];
   logic [23:0] probe_pos [PROBE_CAP][3];
   int          n_targets;
   int          n_probes;
   logic [15:0] inner_r;
   logic [15:0] outer_r;
   logic [23:0] box [3];
   logic        reimage;
   logic        average;
   logic        normalize;

   shell_result_type expected_densities[$];

   function automatic logic [63:0] wrapped_gap(logic [23:0] a, logic [23:0] b,
                                               logic [23:0] period);
      longint      diff;
      logic [63:0] gap;
      logic [63:0] len;
      diff = longint'($signed(a)) - longint'($signed(b));
      gap  = diff < 0 ? 64'(-diff) : 64'(diff);
      len  = 64'(period);
      if (reimage && 2 * gap > len)
         gap = gap > len ? gap - len : len - gap;
      return gap;
   endfunction

   function automatic shell_result_type shell_density_predict();
      shell_result_type res;
      logic [63:0]   ri2, ro2, d2, g, ri3, ro3, tdiv;
      logic [127:0]  num, den, quo;
      logic [23:0]   count;
      logic [1:0]    stat;
      res = '0;
      if (n_targets == 0) begin
         res.status = STATUS_EMPTY;
         return res;
      end
      count = 0;
      stat  = STATUS_OK;
      ri2   = 64'(inner_r) * 64'(inner_r);
      ro2   = 64'(outer_r) * 64'(outer_r);
      for (int t = 0; t < n_targets; t++) begin
         for (int p = 0; p < n_probes; p++) begin
            d2 = 0;
            for (int a = 0; a < 3; a++) begin
               g  = wrapped_gap(probe_pos[p][a], target_pos[t][a], box[a]);
               d2 = d2 + g * g;
            end
            if (d2 >= ri2 && d2 <= ro2) begin
               if (count < CONTACT_MAX) count = count + 1;
               else stat = STATUS_SAT;
            end
         end
      end
      tdiv = average ? 64'(n_targets) : 64'd1;
      if (normalize) begin
         ro3 = ro2 * 64'(outer_r);
         ri3 = ri2 * 64'(inner_r);
         den = ro3 <= ri3 ? 128'd0 : 128'(VOL_K) * 128'(tdiv) * 128'(ro3 - ri3);
         num = 128'(count) << 80;
      end else begin
         den = 128'(tdiv);
         num = 128'(count) << 24;
      end
      if (count == 0) begin
         res.density = 0;
      end else if (den == 0) begin
         res.density = DENSITY_MAX;
         stat = STATUS_SAT;
      end else begin
         quo = num / den;
         if (quo > 128'(DENSITY_MAX)) begin
            res.density = DENSITY_MAX;
            stat = STATUS_SAT;
         end else begin
            res.density = quo[47:0];
         end
      end
      res.contacts = count;
      res.targets  = 11'(n_targets);
      res.status   = stat;
      return res;
   endfunction

   always @(posedge clock) begin
      shell_result_type want;
      if (reset) begin
         n_targets  = 0;
         n_probes   = 0;
         inner_r    = 16'd0;
         outer_r    = 16'd1280;
         box[0]     = 0;
         box[1]     = 0;
         box[2]     = 0;
         reimage    = 1'b1;
         average    = 1'b1;
         normalize  = 1'b1;
         fail_count = 0;
         expected_densities.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_densities.size() == 0) begin
               $error("result with no request outstanding");
               fail_count++;
            end else begin
               want = expected_densities.pop_front();
               if (rsp_density_value !== want.density) begin
                  $error("density_value: expected %0d, got %0d", want.density,
                         rsp_density_value);
                  fail_count++;
               end
               if (rsp_contact_total !== want.contacts) begin
                  $error("contact_total: expected %0d, got %0d", want.contacts,
                         rsp_contact_total);
                  fail_count++;
               end
               if (rsp_targets_used !== want.targets) begin
                  $error("targets_used: expected %0d, got %0d", want.targets,
                         rsp_targets_used);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INNER:     inner_r   = csr_data[15:0];
               REG_OUTER:     outer_r   = csr_data[15:0];
               REG_BOX_X:     box[0]    = csr_data;
               REG_BOX_Y:     box[1]    = csr_data;
               REG_BOX_Z:     box[2]    = csr_data;
               REG_REIMAGE:   reimage   = csr_data[0];
               REG_AVERAGE:   average   = csr_data[0];
               REG_NORMALIZE: normalize = csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_operation)
               OP_LOAD_PROBE: begin
                  if (n_probes < PROBE_CAP) begin
                     probe_pos[n_probes][0] = req_pos_x;
                     probe_pos[n_probes][1] = req_pos_y;
                     probe_pos[n_probes][2] = req_pos_z;
                     n_probes++;
                  end
               end
               OP_LOAD_TARGET: begin
                  if (n_targets < TARGET_CAP) begin
                     target_pos[n_targets][0] = req_pos_x;
                     target_pos[n_targets][1] = req_pos_y;
                     target_pos[n_targets][2] = req_pos_z;
                     n_targets++;
                  end
               end
               OP_COMPUTE: begin
                  expected_densities = {expected_densities, shell_density_predict()};
                  n_targets = 0;
               end
               default: n_probes = 0;
            endcase
         end
      end
      pending = expected_densities.size();
   end

endmodule

>>> dv/spherical_shell_contact_density_test.sv
// ----------------------------------------------------------------------------
// spherical_shell_contact_density_test: stimulus and verdict
// Drives directed and random atom loads, computes and probe clears through
// several register settings, and relies on the checker for every result.
// ----------------------------------------------------------------------------
module spherical_shell_contact_density_test;
   import ssc_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [23:0] req_pos_x;
   logic [23:0] req_pos_y;
   logic [23:0] req_pos_z;
   logic        rsp_valid;
   logic [47:0] rsp_density_value;
   logic [23:0] rsp_contact_total;
   logic [10:0] rsp_targets_used;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;
   int          fail_count;
   int          pending;
   int          requests_sent;
   int          stall_cycles;
   bit          steady;
   int          centre [3];

   spherical_shell_contact_density dut (.*);

   shell_density_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Leaves start high on return, so back-to-back requests need no dip.
   // Busy is steady between edges, so its value here is what the next
   // rising edge sees.
   task automatic send_request(logic [1:0] op, logic [23:0] x, logic [23:0] y,
                               logic [23:0] z);
      if (!steady && $urandom_range(99) < 38) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_pos_z     <= z;
      while (busy) @(negedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0 || busy) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_shell(logic [15:0] inner, logic [15:0] outer, logic [23:0] bx,
                            logic [23:0] by, logic [23:0] bz, bit reim, bit avg,
                            bit norm);
      settle();
      write_reg(REG_INNER, 24'(inner));
      write_reg(REG_OUTER, 24'(outer));
      write_reg(REG_BOX_X, bx);
      write_reg(REG_BOX_Y, by);
      write_reg(REG_BOX_Z, bz);
      write_reg(REG_REIMAGE, 24'(reim));
      write_reg(REG_AVERAGE, 24'(avg));
      write_reg(REG_NORMALIZE, 24'(norm));
   endtask

   function automatic logic [23:0] near_coord(int axis, int spread);
      if ($urandom_range(99) < 8) return 24'($urandom);
      return 24'(centre[axis] + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // Mostly well-formed batches: probes, targets, then a compute, around a
   // shared centre so that pairs fall in and out of the shell.
   task automatic random_batches(int quota, int spread, int region);
      int goal;
      int n;
      goal = requests_sent + quota;
      while (requests_sent < goal) begin
         for (int a = 0; a < 3; a++) centre[a] = $urandom_range(0, region);
         if ($urandom_range(99) < 10) begin
            send_request(2'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
         end else begin
            if ($urandom_range(99) < 30) send_request(OP_CLEAR_PROBE, 0, 0, 0);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
               send_request(OP_LOAD_PROBE, near_coord(0, spread), near_coord(1, spread),
                            near_coord(2, spread));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
               send_request(OP_LOAD_TARGET, near_coord(0, spread), near_coord(1, spread),
                            near_coord(2, spread));
            send_request(OP_COMPUTE, 0, 0, 0);
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OP_LOAD_PROBE;
      req_pos_x     = 0;
      req_pos_y     = 0;
      req_pos_z     = 0;
      csr_valid     = 1'b0;
      csr_index     = REG_INNER;
      csr_data      = 0;
      requests_sent = 0;
      steady        = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: empty target set, coordinate extremes, probe clear.
      send_request(OP_COMPUTE, 0, 0, 0);
      send_request(OP_LOAD_PROBE, 24'h7FFFFF, 24'h800000, 24'h000000);
      send_request(OP_LOAD_PROBE, 0, 0, 0);
      send_request(OP_LOAD_PROBE, 24'd256, 0, 0);
      send_request(OP_LOAD_PROBE, 24'd1280, 0, 0);
      send_request(OP_LOAD_PROBE, 24'd1281, 0, 0);
      send_request(OP_LOAD_TARGET, 0, 0, 0);
      send_request(OP_LOAD_TARGET, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
      send_request(OP_COMPUTE, 0, 0, 0);
      send_request(OP_LOAD_TARGET, 24'hFFFF00, 0, 0);
      send_request(OP_COMPUTE, 0, 0, 0);
      send_request(OP_CLEAR_PROBE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_request(OP_LOAD_TARGET, 0, 0, 0);
      send_request(OP_COMPUTE, 0, 0, 0);
      send_request(OP_LOAD_PROBE, 24'h000100, 24'h000100, 24'h000100);
      send_request(OP_LOAD_TARGET, 0, 0, 0);
      send_request(OP_LOAD_TARGET, 24'h000200, 0, 0);
      send_request(OP_COMPUTE, 0, 0, 0);
      random_batches(15, 1500, 4000);

      // Thin shell with a small periodic box; no idling in this phase.
      set_shell(16'd640, 16'd1280, 24'd2560, 24'd3000, 24'd2048, 1'b1, 1'b1, 1'b1);
      steady = 1'b1;
      random_batches(12, 1500, 3000);
      steady = 1'b0;

      // Widest shell, largest box, no averaging.
      set_shell(16'd0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b1);
      random_batches(12, 40000, 8000000);

      // Degenerate shell: coincident atoms give counts with zero volume.
      set_shell(16'd0, 16'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1, 1'b1);
      random_batches(8, 1, 100);

      // Inverted shell: nothing can be counted.
      set_shell(16'd1280, 16'd256, 24'd512, 24'd512, 24'd512, 1'b1, 1'b1, 1'b1);
      random_batches(8, 1500, 3000);

      // Tiny shell around tightly packed atoms.
      set_shell(16'd0, 16'd3, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1, 1'b1);
      random_batches(12, 2, 1000);

      // Raw counts without volume or averaging, periodic distances off.
      set_shell(16'd100, 16'd2000, 24'd3000, 24'd3000, 24'd3000, 1'b0, 1'b0, 1'b0);
      random_batches(12, 1500, 5000);
      set_shell(16'd0, 16'd1280, 24'd1024, 24'd1024, 24'd1024, 1'b1, 1'b1, 1'b0);
      random_batches(8, 1500, 1024);

      // Full target list: the last loads are dropped. The first stretch of
      // loads runs with no idling at all.
      send_request(OP_CLEAR_PROBE, 0, 0, 0);
      send_request(OP_LOAD_PROBE, 0, 0, 0);
      send_request(OP_LOAD_PROBE, 24'd700, 0, 0);
      steady = 1'b1;
      for (int i = 0; i < 1026; i++) begin
         if (i == 400) steady = 1'b0;
         send_request(OP_LOAD_TARGET, 24'($urandom_range(0, 2000)), 0, 0);
      end
      send_request(OP_COMPUTE, 0, 0, 0);

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/ssc_pkg.sv
src/ssc_axis_gap.sv
src/ssc_divider.sv
src/spherical_shell_contact_density.sv
dv/shell_density_checker.sv
dv/spherical_shell_contact_density_test.sv
